// ===== src/bnm_pkg.sv =====
// Shared types, constants and register codes for the height-to-normal-map stream block.
package bnm_pkg;

  // Field widths
  localparam int PIX_W      = 16;  // height sample
  localparam int SLOPE_W    = 17;  // signed Q17.0 slope
  localparam int DIM_W      = 13;  // frame width / height registers
  localparam int GAIN_W     = 16;  // Q0.16 slope gain
  localparam int COL_W      = 12;  // column counter
  localparam int ROW_W      = 12;  // row counter
  localparam int CFG_DATA_W = 16;  // widest config register
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = ((2 * SLOPE_W + 7) / 8) * 8;

  // Product of a 17-bit signed difference and a 17-bit zero-extended signed gain
  localparam int PROD_W     = SLOPE_W + GAIN_W + 1;
  localparam int FRAC_W     = 16;

  // Geometry limits and reset values
  localparam int DIM_MIN          = 3;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int WIDTH_RESET      = 512;
  localparam int HEIGHT_RESET     = 512;
  localparam int GAIN_RESET       = 51200;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SLOPE_GAIN   = 2'd2
  } cfg_idx_e;

  // One classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pix;        // incoming height sample
    logic [COL_W-1:0] waddr;      // column of this pixel
    logic [COL_W-1:0] raddr;      // column of the next pixel
    logic             has_main;   // row above gets its result now
    logic             interior;   // center pixel is off the border
    logic             has_tail;   // final row: own zero result follows
    logic             tail_last;  // tail result closes the frame
    logic             right_zero; // right neighbor lies past the counter range
  } pix_item_t;

endpackage

// ===== src/bnm_front.sv =====
// Front end: raster position tracking and per-pixel classification.
module bnm_front #(
  parameter int MAX_WIDTH = bnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bnm_pkg::DIM_W-1:0]  frame_width_i,
  input  logic [bnm_pkg::DIM_W-1:0]  frame_height_i,
  input  logic                       in_valid_i,
  input  logic [bnm_pkg::PIX_W-1:0]  in_pix_i,
  input  logic                       q_ready_i,
  output logic                       push_o,
  output bnm_pkg::pix_item_t         item_o
);
  import bnm_pkg::*;

  localparam int MW_W = $clog2(MAX_WIDTH + 1);
  localparam int WL_W = (MW_W > DIM_W) ? MW_W : DIM_W;

  logic [COL_W-1:0] x_q, x_d;
  logic [ROW_W-1:0] y_q, y_d;
  logic [WL_W-1:0]  fw_ext, w_eff, w_last;
  logic [DIM_W-1:0] h_eff, h_last;
  logic             last_col, last_row;

  // Effective geometry, saturated into range
  always_comb begin
    fw_ext = WL_W'(frame_width_i);
    if (fw_ext < WL_W'(DIM_MIN)) begin
      w_eff = WL_W'(DIM_MIN);
    end else if (fw_ext > WL_W'(MAX_WIDTH)) begin
      w_eff = WL_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height_i < DIM_W'(DIM_MIN)) begin
      h_eff = DIM_W'(DIM_MIN);
    end else if (frame_height_i > DIM_W'(HEIGHT_LIMIT)) begin
      h_eff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height_i;
    end
    w_last = w_eff - WL_W'(1);
    h_last = h_eff - DIM_W'(1);
  end

  // A position at or past the last index counts as the last one
  assign last_col = WL_W'(x_q) >= w_last;
  assign last_row = DIM_W'(y_q) >= h_last;

  // Next raster position
  always_comb begin
    x_d = x_q + COL_W'(1);
    y_d = y_q;
    if (last_col) begin
      x_d = '0;
      y_d = last_row ? '0 : y_q + ROW_W'(1);
    end
  end

  assign push_o = in_valid_i && q_ready_i;

  // Classify the beat
  always_comb begin
    item_o.pix        = in_pix_i;
    item_o.waddr      = x_q;
    item_o.raddr      = x_d;
    item_o.has_main   = (y_q != '0);
    item_o.interior   = (x_q != '0) && !last_col && (y_q != ROW_W'(1));
    item_o.has_tail   = last_row;
    item_o.tail_last  = last_col;
    item_o.right_zero = &x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (push_o) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

// ===== src/bnm_queue.sv =====
// Short flop queue that decouples the front end from the back end.
module bnm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bnm_pkg::pix_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bnm_pkg::pix_item_t head_o
);
  import bnm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_item_t        slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");
`endif

endmodule

// ===== src/bnm_back.sv =====
// Back end: line store, neighbor differences, gain multiply and result emission.
module bnm_back #(
  parameter int MAX_WIDTH = bnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [bnm_pkg::GAIN_W-1:0]      gain_i,
  input  logic                            head_valid_i,
  input  bnm_pkg::pix_item_t              head_i,
  output logic                            pop_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [bnm_pkg::OUT_DATA_W-1:0]  m_tdata_o,
  output logic                            m_tlast_o
);
  import bnm_pkg::*;

  localparam int CNT_RANGE = 1 << COL_W;
  localparam int DEPTH     = (MAX_WIDTH < CNT_RANGE) ? MAX_WIDTH : CNT_RANGE;
  localparam int AW        = $clog2(DEPTH);
  localparam int HW_W      = $clog2(DEPTH + 1);
  localparam int WORD_W    = 2 * PIX_W;

  // Store word: row above in the upper half, middle row in the lower half
  logic [WORD_W-1:0] store_mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              rd_ok_q;
  logic [HW_W-1:0]   fill_q;

  logic              adv;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  // Difference stage
  logic              b_vld_q;
  pix_item_t         b_q;
  logic [WORD_W-1:0] cur_q;    // store word of the current column
  logic [PIX_W-1:0]  left_q;   // middle row of the previous column
  logic [WORD_W-1:0] rd_word;
  logic [PIX_W-1:0]  right;
  logic signed [SLOPE_W-1:0] diff_x, diff_y;

  // Multiply stage
  logic              c_vld_q;
  logic              c_main_q, c_tail_q, c_last_q;
  logic signed [SLOPE_W-1:0] dx_q, dy_q;
  logic signed [GAIN_W:0]    gain_s;

  // Emit stage
  logic              d_main_q, d_tail_q, d_last_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic              beat, last_beat;

  // Stage advance: the emit stage frees up when its final beat leaves
  assign m_tvalid_o = d_main_q || d_tail_q;
  assign beat       = m_tvalid_o && m_tready_i;
  assign last_beat  = beat && !(d_main_q && d_tail_q);
  assign adv        = !m_tvalid_o || last_beat;
  assign pop_o      = adv && head_valid_i;

  assign rd_addr = head_i.raddr[AW-1:0];
  assign wr_addr = b_q.waddr[AW-1:0];
  assign wr_en   = adv && b_vld_q;
  assign wr_data = {cur_q[PIX_W-1:0], b_q.pix};

  // Line store: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (pop_o) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  // Columns are written as a growing prefix; entries past it read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (pop_o) begin
        rd_ok_q <= HW_W'(rd_addr) < fill_q;
      end
      if (wr_en && (HW_W'(wr_addr) == fill_q)) begin
        fill_q <= fill_q + HW_W'(1);
      end
    end
  end

  // Neighbor differences
  always_comb begin
    rd_word = rd_ok_q ? rd_q : '0;
    right   = b_q.right_zero ? '0 : rd_word[PIX_W-1:0];
    diff_x  = $signed({1'b0, left_q}) - $signed({1'b0, right});
    diff_y  = $signed({1'b0, cur_q[WORD_W-1:PIX_W]}) - $signed({1'b0, b_q.pix});
  end

  assign gain_s = $signed({1'b0, gain_i});

  // Pipeline control and column history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_main_q <= 1'b0;
      d_tail_q <= 1'b0;
      cur_q    <= '0;
      left_q   <= '0;
    end else begin
      if (adv) begin
        b_vld_q  <= pop_o;
        c_vld_q  <= b_vld_q;
        d_main_q <= c_vld_q && c_main_q;
        d_tail_q <= c_vld_q && c_tail_q;
      end else if (beat) begin
        d_main_q <= 1'b0;
      end
      if (wr_en) begin
        left_q <= cur_q[PIX_W-1:0];
        cur_q  <= rd_word;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q      <= head_i;
      c_main_q <= b_q.has_main;
      c_tail_q <= b_q.has_tail;
      c_last_q <= b_q.tail_last;
      dx_q     <= b_q.interior ? diff_x : '0;
      dy_q     <= b_q.interior ? diff_y : '0;
      d_last_q <= c_last_q;
      px_q     <= dx_q * gain_s;
      py_q     <= dy_q * gain_s;
    end
  end

  // Result beat: slopes first, then the final-row zero beat
  always_comb begin
    m_tdata_o = '0;
    if (d_main_q) begin
      m_tdata_o = OUT_DATA_W'({py_q[FRAC_W +: SLOPE_W], px_q[FRAC_W +: SLOPE_W]});
    end
    m_tlast_o = !d_main_q && d_tail_q && d_last_q;
  end

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && pop_o) |-> (wr_addr != rd_addr))
    else $error("line store read and write hit the same column");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= HW_W'(DEPTH))
    else $error("line store fill count beyond depth");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(b_vld_q) && $stable(c_vld_q) && $stable(cur_q)))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ===== src/bump_to_normal_map_stream_top.sv =====
// Top level of the height-map to normal-map stream converter.
// Takes a 16-bit height image in raster order and returns x and y slopes in
// signed Q17.0 from the central differences of each pixel's neighbors, scaled
// by a Q0.16 gain and rounded toward minus infinity; border pixels give zero.
// The result for a pixel leaves when the pixel below it arrives, so the first
// row gives no beats and each pixel of the last row gives a second, zero beat
// of its own (tlast marks the final one). One pixel is taken per clock while the
// queue has room; in the last row the output port carries two beats per pixel
// and holds the input back. The line store does at most one read and one write
// per clock. Geometry and gain must be written through the config port only
// while the stream is idle; the block does not enforce this. The line store
// needs no clearing after reset.
module bump_to_normal_map_stream_top #(
  parameter int MAX_WIDTH = bnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Config write port
  input  logic                              cfg_we_i,
  input  logic [bnm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bnm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Height pixel stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [bnm_pkg::PIX_W-1:0]         s_axis_tdata_i,   // [15:0] height_sample
  // Slope stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [bnm_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,   // [16:0] slope_x, [33:17] slope_y
  output logic                              m_axis_tlast_o    // frame_last
);
  import bnm_pkg::*;

  logic [DIM_W-1:0]  frame_width_q, frame_height_q;
  logic [GAIN_W-1:0] slope_gain_q;

  logic      push, q_full, q_empty, pop;
  pix_item_t push_item, head_item;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(WIDTH_RESET);
      frame_height_q <= DIM_W'(HEIGHT_RESET);
      slope_gain_q   <= GAIN_W'(GAIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_SLOPE_GAIN:   slope_gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !q_full;

  bnm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_pix_i      (s_axis_tdata_i),
    .q_ready_i     (!q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  bnm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_item)
  );

  bnm_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (slope_gain_q),
    .head_valid_i(!q_empty),
    .head_i      (head_item),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule
